### rtl/core/iee_pkg.sv
// Shared types, constants and helpers for the infix expression evaluator.
// Depends on nothing; every other file of the block but iee_in_if imports it.
package iee_pkg;

	// Internal arithmetic width and result port width
	localparam int VALUE_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0]   val_t;
	typedef logic [2*VALUE_WIDTH-1:0] prod_t;
	typedef logic [CNT_WIDTH-1:0]     cnt_t;

	localparam val_t VSIGN   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam val_t VMAXPOS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam val_t TEN     = val_t'(10);

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIVZERO  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_MUL  = 2'd1,
		PEND_DIV  = 2'd2
	} pend_t;

	typedef enum logic [1:0] {
		CC_OTHER,
		CC_DIGIT,
		CC_ADDSUB,
		CC_MULDIV
	} char_class_t;

	// Datapath micro-operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_MUL_START,
		DP_MUL_DONE,
		DP_ADD_DIGIT,
		DP_DIV_START,
		DP_TERM_LOAD,
		DP_CLOSE_TERM,
		DP_SET_PEND,
		DP_EMIT
	} dp_op_t;

	// Multiplier operand pair, also picks the destination on completion
	typedef enum logic {
		MUL_ACC_TEN,
		MUL_TERM_ACC
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DIG_MULW,
		S_DIG_ADD,
		S_CN,
		S_CN_MULW,
		S_CN_DIV,
		S_AFTER_CN,
		S_EMIT
	} ctrl_state_t;

	typedef enum logic {
		PH_OP,
		PH_LAST
	} phase_t;

	typedef struct packed {
		logic     capture;
		dp_op_t   op;
		mul_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		char_class_t char_class;
		logic        is_last;
		pend_t       pend;
		logic        div_busy;
	} dp_stat_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cc;
		if (c >= CH_ZERO && c <= CH_NINE)
			cc = CC_DIGIT;
		else if (c == CH_PLUS || c == CH_MINUS)
			cc = CC_ADDSUB;
		else if (c == CH_STAR || c == CH_SLASH)
			cc = CC_MULDIV;
		else
			cc = CC_OTHER;
		return cc;
	endfunction

	// Absolute value of a two's complement word (most negative maps to itself)
	function automatic val_t mag(input val_t v);
		return v[VALUE_WIDTH-1] ? val_t'(-v) : v;
	endfunction

endpackage

### rtl/core/iee_in_if.sv
// Character channel of the expression evaluator: valid/ready plus payload.
// Depends on nothing.
interface iee_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

### rtl/core/iee_out_if.sv
// Result channel of the expression evaluator: valid/ready plus value and status.
// Depends on iee_pkg for the result width.
interface iee_out_if;
	import iee_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [OUT_WIDTH-1:0] value;
	logic [1:0]                  status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

### rtl/core/iee_datapath.sv
// Datapath: expression state, multiplier, serial divider, adder and result register.
// Depends on iee_pkg; driven by iee_ctrl through dp_cmd_t, reports dp_stat_t.
module iee_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  char_code,
	input  logic                        is_last,
	input  iee_pkg::dp_cmd_t            cmd,
	output iee_pkg::dp_stat_t           stat,
	output logic signed [iee_pkg::OUT_WIDTH-1:0] res_value,
	output logic [1:0]                  res_status
);
	import iee_pkg::*;

	localparam int MSB = VALUE_WIDTH - 1;

	// Captured transaction
	logic [7:0] char_q;
	logic       last_q;

	// Expression state
	val_t    sum_q, sum_d;
	val_t    term_q, term_d;
	val_t    accum_q, accum_d;
	logic    neg_q, neg_d;
	pend_t   pend_q, pend_d;
	status_t err_q, err_d;

	// Multiplier stage
	prod_t prod_s1;
	logic  mneg_s1;

	// Divider
	val_t rem_q, rem_d;
	val_t quo_q, quo_d;
	val_t dvsr_q, dvsr_d;
	logic dneg_q, dneg_d;
	cnt_t cnt_q, cnt_d;
	logic busy_q, busy_d;

	// Result register
	logic [OUT_WIDTH-1:0] res_value_q;
	status_t              res_status_q;

	val_t    mul_a, mul_b, mul_lim, mul_lo, mul_res;
	logic    mul_ovf;
	val_t    add_res;
	logic    add_ovf;
	val_t    cs_res;
	logic    cs_ovf;
	logic [VALUE_WIDTH:0] rem_sh, trial;
	logic    div_ge;
	val_t    rem_nx, quo_nx, div_res;
	logic    div_ovf;
	logic    flag;
	status_t flag_code;

	// Operand select and completion arithmetic
	always_comb begin
		mul_a   = (cmd.sel == MUL_TERM_ACC) ? term_q : accum_q;
		mul_b   = (cmd.sel == MUL_TERM_ACC) ? accum_q : TEN;
		mul_lim = mneg_s1 ? VSIGN : VMAXPOS;
		mul_ovf = prod_s1 > prod_t'(mul_lim);
		mul_lo  = prod_s1[MSB:0];
		mul_res = mneg_s1 ? val_t'(-mul_lo) : mul_lo;

		add_res = accum_q + val_t'(char_q - CH_ZERO);
		add_ovf = !accum_q[MSB] && add_res[MSB];

		cs_res = neg_q ? (sum_q - term_q) : (sum_q + term_q);
		if (neg_q)
			cs_ovf = (sum_q[MSB] != term_q[MSB]) && (cs_res[MSB] != sum_q[MSB]);
		else
			cs_ovf = (sum_q[MSB] == term_q[MSB]) && (cs_res[MSB] != sum_q[MSB]);

		// one restoring quotient bit
		rem_sh  = {rem_q, quo_q[MSB]};
		trial   = rem_sh - {1'b0, dvsr_q};
		div_ge  = !trial[VALUE_WIDTH];
		rem_nx  = div_ge ? trial[MSB:0] : rem_sh[MSB:0];
		quo_nx  = {quo_q[MSB-1:0], div_ge};
		div_res = dneg_q ? val_t'(-quo_nx) : quo_nx;
		div_ovf = !dneg_q && quo_nx[MSB];
	end

	// Next state of the expression and divider
	always_comb begin
		sum_d     = sum_q;
		term_d    = term_q;
		accum_d   = accum_q;
		neg_d     = neg_q;
		pend_d    = pend_q;
		err_d     = err_q;
		rem_d     = rem_q;
		quo_d     = quo_q;
		dvsr_d    = dvsr_q;
		dneg_d    = dneg_q;
		cnt_d     = cnt_q;
		busy_d    = busy_q;
		flag      = 1'b0;
		flag_code = ST_OVERFLOW;

		unique case (cmd.op)
			DP_MUL_DONE: begin
				if (cmd.sel == MUL_TERM_ACC) begin
					term_d  = mul_res;
					accum_d = '0;
					pend_d  = PEND_NONE;
				end else begin
					accum_d = mul_res;
				end
				flag = mul_ovf;
			end
			DP_ADD_DIGIT: begin
				accum_d = add_res;
				flag    = add_ovf;
			end
			DP_DIV_START: begin
				if (accum_q == '0) begin
					term_d    = '0;
					accum_d   = '0;
					pend_d    = PEND_NONE;
					flag      = 1'b1;
					flag_code = ST_DIVZERO;
				end else begin
					rem_d  = '0;
					quo_d  = mag(term_q);
					dvsr_d = mag(accum_q);
					dneg_d = term_q[MSB] ^ accum_q[MSB];
					cnt_d  = cnt_t'(VALUE_WIDTH);
					busy_d = 1'b1;
				end
			end
			DP_TERM_LOAD: begin
				term_d  = accum_q;
				accum_d = '0;
				pend_d  = PEND_NONE;
			end
			DP_CLOSE_TERM: begin
				sum_d  = cs_res;
				flag   = cs_ovf;
				term_d = '0;
				neg_d  = (char_q == CH_MINUS);
			end
			DP_SET_PEND: begin
				pend_d = (char_q == CH_STAR) ? PEND_MUL : PEND_DIV;
			end
			DP_EMIT: begin
				sum_d   = '0;
				term_d  = '0;
				accum_d = '0;
				neg_d   = 1'b0;
				pend_d  = PEND_NONE;
				err_d   = ST_OK;
			end
			default: begin
			end
		endcase

		// divider iteration; the controller issues nothing else meanwhile
		if (busy_q) begin
			rem_d = rem_nx;
			quo_d = quo_nx;
			cnt_d = cnt_q - cnt_t'(1);
			if (cnt_q == cnt_t'(1)) begin
				busy_d  = 1'b0;
				term_d  = div_res;
				accum_d = '0;
				pend_d  = PEND_NONE;
				flag    = div_ovf;
			end
		end

		// first error sticks
		if (flag && err_q == ST_OK)
			err_d = flag_code;
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			term_q  <= '0;
			accum_q <= '0;
			neg_q   <= 1'b0;
			pend_q  <= PEND_NONE;
			err_q   <= ST_OK;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			sum_q   <= sum_d;
			term_q  <= term_d;
			accum_q <= accum_d;
			neg_q   <= neg_d;
			pend_q  <= pend_d;
			err_q   <= err_d;
			cnt_q   <= cnt_d;
			busy_q  <= busy_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			char_q <= char_code;
			last_q <= is_last;
		end
		if (cmd.op == DP_MUL_START) begin
			prod_s1 <= prod_t'(mag(mul_a)) * prod_t'(mag(mul_b));
			mneg_s1 <= mul_a[MSB] ^ mul_b[MSB];
		end
		if (cmd.op == DP_EMIT) begin
			res_value_q  <= OUT_WIDTH'(sum_q);
			res_status_q <= err_q;
		end
		rem_q  <= rem_d;
		quo_q  <= quo_d;
		dvsr_q <= dvsr_d;
		dneg_q <= dneg_d;
	end

	assign stat.char_class = classify(char_q);
	assign stat.is_last    = last_q;
	assign stat.pend       = pend_q;
	assign stat.div_busy   = busy_q;

	assign res_value  = $signed(res_value_q);
	assign res_status = res_status_q;

endmodule

### rtl/core/iee_ctrl.sv
// Controller: sequences datapath micro-operations for each character.
// Depends on iee_pkg; talks to iee_datapath only through dp_cmd_t / dp_stat_t.
module iee_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  iee_pkg::dp_stat_t stat,
	output iee_pkg::dp_cmd_t  cmd
);
	import iee_pkg::*;

	ctrl_state_t state_q, state_d;
	phase_t      phase_q, phase_d;
	logic        out_valid_q, out_valid_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_OP;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.op      = DP_NOP;
		cmd.sel     = MUL_ACC_TEN;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.char_class)
					CC_DIGIT: begin
						cmd.op  = DP_MUL_START;
						cmd.sel = MUL_ACC_TEN;
						state_d = S_DIG_MULW;
					end
					CC_ADDSUB, CC_MULDIV: begin
						phase_d = PH_OP;
						state_d = S_CN;
					end
					CC_OTHER: begin
						if (stat.is_last) begin
							phase_d = PH_LAST;
							state_d = S_CN;
						end else begin
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_DIG_MULW: begin
				cmd.op  = DP_MUL_DONE;
				cmd.sel = MUL_ACC_TEN;
				state_d = S_DIG_ADD;
			end
			S_DIG_ADD: begin
				cmd.op = DP_ADD_DIGIT;
				if (stat.is_last) begin
					phase_d = PH_LAST;
					state_d = S_CN;
				end else begin
					state_d = S_IDLE;
				end
			end
			// close the number into the open term
			S_CN: begin
				unique case (stat.pend)
					PEND_MUL: begin
						cmd.op  = DP_MUL_START;
						cmd.sel = MUL_TERM_ACC;
						state_d = S_CN_MULW;
					end
					PEND_DIV: begin
						cmd.op  = DP_DIV_START;
						state_d = S_CN_DIV;
					end
					default: begin
						cmd.op  = DP_TERM_LOAD;
						state_d = S_AFTER_CN;
					end
				endcase
			end
			S_CN_MULW: begin
				cmd.op  = DP_MUL_DONE;
				cmd.sel = MUL_TERM_ACC;
				state_d = S_AFTER_CN;
			end
			S_CN_DIV: begin
				if (!stat.div_busy)
					state_d = S_AFTER_CN;
			end
			S_AFTER_CN: begin
				if (phase_q == PH_LAST) begin
					cmd.op  = DP_CLOSE_TERM;
					state_d = S_EMIT;
				end else begin
					cmd.op = (stat.char_class == CC_ADDSUB) ? DP_CLOSE_TERM : DP_SET_PEND;
					if (stat.is_last) begin
						phase_d = PH_LAST;
						state_d = S_CN;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = DP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result valid flag
	assign out_valid_d = (cmd.op == DP_EMIT) || (out_valid_q && !out_ready);
	assign out_valid   = out_valid_q;

endmodule

### rtl/core/infix_expression_evaluator_core.sv
// Streaming evaluator for infix expressions of non-negative decimal integers and + - * /,
// one ASCII character per transaction; other characters are skipped. * and / bind tighter
// than + and -, division truncates toward zero, and all arithmetic wraps at VALUE_WIDTH bits.
// The transaction flagged is_last closes the expression and yields one result: the value and
// a sticky status (0 ok, 1 divide by zero, 2 overflow, first error kept); state then clears.
// One character is worked on at a time. A digit is accepted, multiplied by ten through the
// product register and then added. An operator first closes the number into the open term,
// through the multiplier after a pending multiply or the divider after a pending divide, the
// divider producing one quotient bit per cycle (skipped for a zero divisor). The last
// character adds another close of the number, then the term is folded and the result is
// loaded into its register; the load waits while an earlier result has not been taken.
// A new character is accepted while a result still waits on the result channel.
// Depends on iee_pkg, iee_in_if, iee_out_if, iee_ctrl and iee_datapath.
module infix_expression_evaluator_core (
	input  logic      clk,
	input  logic      arst_n,
	iee_in_if.sink    expr,
	iee_out_if.source result
);
	import iee_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Sequencer
	iee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (expr.valid),
		.in_ready  (expr.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// Arithmetic and state
	iee_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (expr.char_code),
		.is_last    (expr.is_last),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.res_value  (result.value),
		.res_status (result.status)
	);

	// No other micro-operation or capture while the divider iterates
	assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.div_busy |-> (dp_cmd.op == DP_NOP && !dp_cmd.capture))
		else $error("datapath command issued while divider busy");

	// A result is never loaded over one that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == DP_EMIT) |-> (!result.valid || result.ready))
		else $error("pending result overwritten");

	// Loading the result raises valid with a legal status code
	assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == DP_EMIT) |=> (result.valid &&
			(result.status == ST_OK || result.status == ST_DIVZERO ||
			 result.status == ST_OVERFLOW)))
		else $error("result not presented after load");

	// An accepted character is always worked on before the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		(expr.valid && expr.ready) |=> !expr.ready)
		else $error("back-to-back character accept");

endmodule
